// ===== sv/quaternion_to_euler_macros.svh =====
// Assertion macros for the quaternion to Euler angle block.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// consequent must hold whenever antecedent holds
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold on every clock
`define QTE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== sv/qte_pkg.sv =====
// Shared types, widths and tables of the quaternion to Euler angle block.
package qte_pkg;

    localparam int IN_W       = 16;
    localparam int ANG_W      = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 34;
    localparam int S_W        = 30;
    localparam int SQ_W       = 58;
    localparam int SQRT_STEPS = 29;
    localparam int DATA_W     = 45;
    localparam int MAG_W      = 42;
    localparam int NORM_STEPS = 6;
    localparam int Z_W        = 34;
    localparam int TABLE_LEN  = 24;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic signed [SUM_W-1:0] ONE_Q28    = 34'sh10000000;
    localparam logic        [SQ_W-1:0]  ONE_SQ     = SQ_W'(1) << (2 * (SQRT_STEPS - 1));
    localparam logic signed [Z_W-1:0]   QUARTER    = 34'sh40000000;
    localparam logic signed [Z_W-1:0]   ROUND_HALF = 34'sh8000;

    typedef struct packed {
        logic signed [SUM_W-1:0] a1;
        logic signed [SUM_W-1:0] b1;
        logic signed [SUM_W-1:0] a3;
        logic signed [SUM_W-1:0] b3;
        logic signed [S_W-1:0]   s;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic y_neg;
    } flags_t;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        flags_t                f;
    } lane_out_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_tab(input int i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:       v = 34'sh20000000;
            1:       v = 34'sh12E4051E;
            2:       v = 34'sh09FB385B;
            3:       v = 34'sh051111D4;
            4:       v = 34'sh028B0D43;
            5:       v = 34'sh0145D7E1;
            6:       v = 34'sh00A2F61E;
            7:       v = 34'sh00517C55;
            8:       v = 34'sh0028BE53;
            9:       v = 34'sh00145F2F;
            10:      v = 34'sh000A2F98;
            11:      v = 34'sh000517CC;
            12:      v = 34'sh00028BE6;
            13:      v = 34'sh000145F3;
            14:      v = 34'sh0000A2FA;
            15:      v = 34'sh0000517D;
            16:      v = 34'sh000028BE;
            17:      v = 34'sh0000145F;
            18:      v = 34'sh00000A30;
            19:      v = 34'sh00000518;
            20:      v = 34'sh0000028C;
            21:      v = 34'sh00000146;
            22:      v = 34'sh000000A3;
            23:      v = 34'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round 2^-32 turn to 2^-16 turn, wrapped
    function automatic logic [ANG_W-1:0] to_bam(input logic signed [Z_W-1:0] z);
        logic signed [Z_W-1:0] t;
        t = z + ROUND_HALF;
        return t[2*ANG_W-1:ANG_W];
    endfunction

endpackage

// ===== sv/qte_front.sv =====
// Front end: products and sums of the quaternion terms, pushed into the queue.
module qte_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_w,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_x,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_y,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_z,
    input  logic                                q_full,
    output logic                                push,
    output qte_pkg::item_t                      item
);

    localparam int PW = qte_pkg::PROD_W;
    localparam int SW = qte_pkg::SUM_W;

    logic v1_reg, v2_reg;
    logic en;
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] yz_reg, xw_reg, xy_reg, zw_reg, xz_reg, yw_reg;
    qte_pkg::item_t item_reg, item_next;
    logic signed [SW-1:0] s_full;

    assign en       = !v2_reg || !q_full;
    assign in_ready = en;
    assign push     = v2_reg && !q_full;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg   <= quat_w * quat_w;
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            zz_reg   <= quat_z * quat_z;
            yz_reg   <= quat_y * quat_z;
            xw_reg   <= quat_x * quat_w;
            xy_reg   <= quat_x * quat_y;
            zw_reg   <= quat_z * quat_w;
            xz_reg   <= quat_x * quat_z;
            yw_reg   <= quat_y * quat_w;
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        item_next.a1 = (SW'(yz_reg) + SW'(xw_reg)) <<< 1;
        item_next.b1 = -SW'(xx_reg) - SW'(yy_reg) + SW'(zz_reg) + SW'(ww_reg);
        item_next.a3 = (SW'(xy_reg) + SW'(zw_reg)) <<< 1;
        item_next.b3 = SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg) + SW'(ww_reg);
        s_full       = (SW'(xz_reg) - SW'(yw_reg)) <<< 1;
        priority if (s_full > qte_pkg::ONE_Q28)
            item_next.s = qte_pkg::ONE_Q28[qte_pkg::S_W-1:0];
        else if (s_full < -qte_pkg::ONE_Q28)
            item_next.s = qte_pkg::S_W'(-qte_pkg::ONE_Q28);
        else
            item_next.s = s_full[qte_pkg::S_W-1:0];
    end

endmodule

// ===== sv/qte_fifo.sv =====
// Short transaction queue between the front end and the angle pipeline.
module qte_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qte_pkg::item_t  din,
    input  logic            pop,
    output qte_pkg::item_t  dout,
    output qte_pkg::qstat_t stat
);

    localparam int D  = qte_pkg::QUEUE_DEPTH;
    localparam int PW = qte_pkg::QPTR_W;
    localparam int CW = qte_pkg::QCNT_W;

    qte_pkg::item_t mem [D];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign dout       = mem[rp_reg];
    assign stat.count = cnt_reg;
    assign stat.full  = (cnt_reg == CW'(D));
    assign stat.empty = (cnt_reg == '0);
    assign cnt_next   = cnt_reg + CW'(push) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= din;
    end

endmodule

// ===== sv/qte_lane.sv =====
// One atan2 lane: normalize, quadrant fold and pipelined vectoring CORDIC.
module qte_lane #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::SUM_W-1:0]  y_in,
    input  logic signed [qte_pkg::SUM_W-1:0]  x_in,
    output qte_pkg::lane_out_t                res
);

    localparam int DW  = qte_pkg::DATA_W;
    localparam int MW  = qte_pkg::MAG_W;
    localparam int ZW  = qte_pkg::Z_W;
    localparam int NS  = qte_pkg::NORM_STEPS;
    localparam int CS  = CORDIC_STEPS;
    localparam int TOT = NS + 2 + CS;

    logic signed [DW-1:0] nx_reg [NS+1];
    logic signed [DW-1:0] ny_reg [NS+1];
    logic        [MW-1:0] nm_reg [NS+1];
    logic signed [DW-1:0] cx_reg [CS+1];
    logic signed [DW-1:0] cy_reg [CS+1];
    logic signed [ZW-1:0] cz_reg [CS+1];
    qte_pkg::flags_t      f_reg  [TOT];

    logic [MW-1:0] ax, ay;
    qte_pkg::flags_t f_in;

    assign ax = MW'(x_in[qte_pkg::SUM_W-1] ? -x_in : x_in);
    assign ay = MW'(y_in[qte_pkg::SUM_W-1] ? -y_in : y_in);
    assign f_in.x_zero = (x_in == '0);
    assign f_in.y_zero = (y_in == '0);
    assign f_in.y_neg  = y_in[qte_pkg::SUM_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg[0] <= DW'(x_in);
            ny_reg[0] <= DW'(y_in);
            nm_reg[0] <= (ax > ay) ? ax : ay;
            f_reg[0]  <= f_in;
        end
    end

    genvar g;
    generate
        for (g = 1; g < TOT; g++)
        begin : g_flags
            always_ff @(posedge clk)
            begin
                if (en)
                    f_reg[g] <= f_reg[g-1];
            end
        end

        for (g = 0; g < NS; g++)
        begin : g_norm
            localparam int SH = 1 << (NS - 1 - g);
            logic fits;
            assign fits = ((nm_reg[g] >> (MW - 1 - SH)) == '0);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nx_reg[g+1] <= fits ? (nx_reg[g] <<< SH) : nx_reg[g];
                    ny_reg[g+1] <= fits ? (ny_reg[g] <<< SH) : ny_reg[g];
                    nm_reg[g+1] <= fits ? (nm_reg[g] << SH) : nm_reg[g];
                end
            end
        end

        for (g = 0; g < CS; g++)
        begin : g_cordic
            logic signed [DW-1:0] xs, ys;
            assign xs = cx_reg[g] >>> g;
            assign ys = cy_reg[g] >>> g;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy_reg[g][DW-1])
                    begin
                        cx_reg[g+1] <= cx_reg[g] + ys;
                        cy_reg[g+1] <= cy_reg[g] - xs;
                        cz_reg[g+1] <= cz_reg[g] + qte_pkg::atan_tab(g);
                    end
                    else
                    begin
                        cx_reg[g+1] <= cx_reg[g] - ys;
                        cy_reg[g+1] <= cy_reg[g] + xs;
                        cz_reg[g+1] <= cz_reg[g] - qte_pkg::atan_tab(g);
                    end
                end
            end
        end
    endgenerate

    // fold left half plane by a quarter turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (nx_reg[NS][DW-1] && !ny_reg[NS][DW-1])
            begin
                cx_reg[0] <= ny_reg[NS];
                cy_reg[0] <= -nx_reg[NS];
                cz_reg[0] <= qte_pkg::QUARTER;
            end
            else if (nx_reg[NS][DW-1])
            begin
                cx_reg[0] <= -ny_reg[NS];
                cy_reg[0] <= nx_reg[NS];
                cz_reg[0] <= -qte_pkg::QUARTER;
            end
            else
            begin
                cx_reg[0] <= nx_reg[NS];
                cy_reg[0] <= ny_reg[NS];
                cz_reg[0] <= '0;
            end
        end
    end

    assign res.z = cz_reg[CS];
    assign res.f = f_reg[TOT-1];

endmodule

// ===== sv/qte_back.sv =====
// Back end: pipelined square root, three atan2 lanes and output rounding.
module qte_back #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qte_pkg::item_t                     q_item,
    input  qte_pkg::qstat_t                    q_stat,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_first,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_second,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_third
);

    localparam int QW  = qte_pkg::SQ_W;
    localparam int SR  = qte_pkg::SQRT_STEPS;
    localparam int SW  = qte_pkg::SUM_W;
    localparam int ZW  = qte_pkg::Z_W;
    localparam int AW  = qte_pkg::ANG_W;
    localparam int LL  = qte_pkg::NORM_STEPS + 2 + CORDIC_STEPS;
    localparam int BL  = 1 + SR + LL + 1;

    logic [BL-1:0] vld_reg;
    logic en;

    logic [QW-1:0]  sv_reg [SR+1];
    logic [QW-1:0]  sr_reg [SR+1];
    qte_pkg::item_t it_reg [SR+1];

    logic signed [2*qte_pkg::S_W-1:0] s_sq;
    logic signed [SW-1:0] c_val;
    qte_pkg::lane_out_t l1, l2, l3;
    logic [AW-1:0] a1_reg, a2_reg, a3_reg;

    assign en        = !vld_reg[BL-1] || out_ready;
    assign pop       = en && !q_stat.empty;
    assign out_valid = vld_reg[BL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[BL-2:0], !q_stat.empty};
    end

    assign s_sq = q_item.s * q_item.s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg[0] <= qte_pkg::ONE_SQ - QW'(s_sq);
            sr_reg[0] <= '0;
            it_reg[0] <= q_item;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SR; k++)
        begin : g_sqrt
            localparam logic [QW-1:0] BIT = QW'(1) << (2 * (SR - 1 - k));
            logic [QW-1:0] trial;
            assign trial = sr_reg[k] + BIT;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (sv_reg[k] >= trial)
                    begin
                        sv_reg[k+1] <= sv_reg[k] - trial;
                        sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                    end
                    else
                    begin
                        sv_reg[k+1] <= sv_reg[k];
                        sr_reg[k+1] <= sr_reg[k] >> 1;
                    end
                    it_reg[k+1] <= it_reg[k];
                end
            end
        end
    endgenerate

    assign c_val = $signed({1'b0, sr_reg[SR][SW-2:0]});

    qte_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane1 (
        .clk  (clk),
        .en   (en),
        .y_in (it_reg[SR].a1),
        .x_in (it_reg[SR].b1),
        .res  (l1)
    );

    qte_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane2 (
        .clk  (clk),
        .en   (en),
        .y_in (SW'(it_reg[SR].s)),
        .x_in (c_val),
        .res  (l2)
    );

    qte_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane3 (
        .clk  (clk),
        .en   (en),
        .y_in (it_reg[SR].a3),
        .x_in (it_reg[SR].b3),
        .res  (l3)
    );

    function automatic logic signed [ZW-1:0] pick(input qte_pkg::lane_out_t l);
        logic signed [ZW-1:0] r;
        priority if (l.f.x_zero && l.f.y_zero)
            r = '0;
        else if (l.f.x_zero)
            r = l.f.y_neg ? -qte_pkg::QUARTER : qte_pkg::QUARTER;
        else
            r = l.z;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= qte_pkg::to_bam(pick(l1));
            a2_reg <= qte_pkg::to_bam(-pick(l2));
            a3_reg <= qte_pkg::to_bam(pick(l3));
        end
    end

    assign angle_first  = $signed(a1_reg);
    assign angle_second = $signed(a2_reg);
    assign angle_third  = $signed(a3_reg);

endmodule

// ===== sv/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle converter.
//
// Input channel: in_valid/in_ready carry one quaternion (quat_w, quat_x,
// quat_y, quat_z, signed Q1.14) per transaction. Output channel:
// out_valid/out_ready carry angle_first, angle_second and angle_third as
// signed binary angles, 32768 = pi.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the fully pipelined square root (one result bit per stage) and CORDIC
// (one iteration per stage). From the accepting edge to out_valid the
// path runs through 2 front stages (the first loaded at the accepting edge),
// 1 queue write, 1 square stage, 29 root stages, 8 + CORDIC_STEPS lane
// stages, 1 rounding stage.
// A four entry queue sits between the front end and the angle pipeline.
// When out_valid is high and out_ready is low the angle pipeline holds;
// the front end keeps taking transactions until the queue fills, then in_ready drops.
// Reset clears all valid flags and the queue; no transaction is in flight
// afterwards. Data registers and queue contents are not reset.
`include "quaternion_to_euler_macros.svh"
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [qte_pkg::IN_W-1:0]    quat_w,
    input  logic signed [qte_pkg::IN_W-1:0]    quat_x,
    input  logic signed [qte_pkg::IN_W-1:0]    quat_y,
    input  logic signed [qte_pkg::IN_W-1:0]    quat_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_first,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_second,
    output logic signed [qte_pkg::ANG_W-1:0]   angle_third
);

    localparam logic [qte_pkg::QCNT_W-1:0] Q_MAX = qte_pkg::QCNT_W'(qte_pkg::QUEUE_DEPTH);

    logic            push, pop;
    qte_pkg::item_t  f_item, q_item;
    qte_pkg::qstat_t q_stat;
    logic            second_in_range;

    assign second_in_range = (angle_second >= -16'sd16384) && (angle_second <= 16'sd16384);

    qte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .q_full   (q_stat.full),
        .push     (push),
        .item     (f_item)
    );

    qte_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_item),
        .pop   (pop),
        .dout  (q_item),
        .stat  (q_stat)
    );

    qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .angle_first  (angle_first),
        .angle_second (angle_second),
        .angle_third  (angle_third)
    );

    `QTE_ASSERT_IMP(a_second_range, out_valid, second_in_range, "second angle out of range")
    `QTE_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= Q_MAX, "queue count overflow")
    `QTE_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule
